/* hw/rtl/ipv4_receive_header_filter_assert.svh */
// Assertion macros for the IPv4 receive header filter top level.
`ifndef IPV4_RECEIVE_HEADER_FILTER_ASSERT_SVH
`define IPV4_RECEIVE_HEADER_FILTER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define IRHF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define IRHF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/irhf_pkg.sv */
// Types and constants for the IPv4 receive header filter.
package irhf_pkg;

   // Default width of the packet byte counter.
   localparam int COUNT_BITS_DEFAULT = 16;

   // Smallest legal IPv4 header, in bytes.
   localparam int MIN_HDR_BYTES = 20;

   localparam logic [3:0]  IP_VERSION_4   = 4'd4;
   localparam logic [31:0] ADDR_BROADCAST = 32'hFFFF_FFFF;
   localparam logic [31:0] ADDR_NONE      = 32'h0000_0000;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   // Verdict codes.
   typedef enum logic [2:0] {
      STATUS_ACCEPT      = 3'd0,
      STATUS_TOO_SHORT   = 3'd1,
      STATUS_BAD_VERSION = 3'd2,
      STATUS_BAD_HLEN    = 3'd3,
      STATUS_NOT_OURS    = 3'd4
   } status_type;

   // Protocol classes.
   typedef enum logic [1:0] {
      CLASS_ICMP  = 2'd0,
      CLASS_TCP   = 2'd1,
      CLASS_UDP   = 2'd2,
      CLASS_OTHER = 2'd3
   } proto_class_type;

   // Header fields captured while the packet streams past.
   typedef struct packed {
      logic [7:0]  ver_ihl_byte;
      logic [15:0] tot_len_word;
      logic [7:0]  ttl;
      logic [7:0]  protocol;
      logic [31:0] source;
      logic [31:0] destination;
   } hdr_type;

   // Maps a protocol byte onto its class.
   function automatic proto_class_type class_of(input logic [7:0] protocol);
      proto_class_type result;
      case (protocol)
         PROTO_ICMP: result = CLASS_ICMP;
         PROTO_TCP:  result = CLASS_TCP;
         PROTO_UDP:  result = CLASS_UDP;
         default:    result = CLASS_OTHER;
      endcase
      return result;
   endfunction

endpackage

/* hw/rtl/ipv4_receive_header_filter.sv */
// Top level of the IPv4 receive header filter.
//
// Usage: packet bytes enter on the req_ channel (valid/ready), header first,
// with req_last high on the final byte of each packet. For each packet one
// verdict transaction leaves on the rsp_ channel: status, protocol class,
// protocol, TTL, both addresses, header length and payload length.
// The local address is written through csr_write_enable / csr_write_data
// while the block is idle; zero means no address is assigned.
// Throughput: one byte per clock while the output side keeps up.
// Path: the final byte sets the pending flag, and the verdict then moves into
// the output register once that register is free; the header registers feed
// one level of compare logic into the output register.
// A finished verdict waits in the output register while the next packet's
// bytes keep flowing. Only when a second verdict is ready while the first is
// still held does req_ready drop, until the receiver takes the first one.
// Reset (synchronous, active high) clears the byte count, the captured header,
// the local address and both valid flags.
module ipv4_receive_header_filter #(
   parameter int COUNT_BITS = irhf_pkg::COUNT_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // Configuration
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data,
   // Packet bytes
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last,
   // Verdicts
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [1:0]         rsp_proto_class,
   output logic [7:0]         rsp_protocol_number,
   output logic [7:0]         rsp_time_to_live,
   output logic [31:0]        rsp_source_address,
   output logic [31:0]        rsp_destination_address,
   output logic [5:0]         rsp_header_bytes,
   output logic signed [16:0] rsp_payload_size,
   output logic               rsp_broadcast
);
   import irhf_pkg::*;

   `include "ipv4_receive_header_filter_assert.svh"

   logic                  take;
   logic                  out_load;
   logic                  pending;
   logic [COUNT_BITS-1:0] packet_length;
   hdr_type               header;

   logic [31:0]           our_address_ff;

   status_type            status;
   logic [5:0]            hdr_bytes;
   logic                  bcast;
   logic                  short_pkt;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            status_ff;
   logic [1:0]            class_ff;
   logic [7:0]            protocol_ff;
   logic [7:0]            ttl_ff;
   logic [31:0]           source_ff;
   logic [31:0]           destination_ff;
   logic [5:0]            hdr_bytes_ff;
   logic [16:0]           payload_ff;
   logic                  bcast_ff;

   // Local address register.
   always_ff @(posedge clock) begin
      if (reset) begin
         our_address_ff <= '0;
      end else if (csr_write_enable) begin
         our_address_ff <= csr_write_data;
      end
   end

   // A held verdict moves to the output register when that register is free.
   assign out_load  = pending && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !pending || out_load;
   assign take      = req_valid && req_ready;

   irhf_capture #(
      .COUNT_BITS(COUNT_BITS)
   ) u_capture (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .data_byte      (req_data_byte),
      .last           (req_last),
      .release_verdict(out_load),
      .pending        (pending),
      .packet_length  (packet_length),
      .header         (header)
   );

   // Verdict checks, in priority order.
   assign hdr_bytes = {header.ver_ihl_byte[3:0], 2'b00};
   assign bcast     = (header.destination == ADDR_BROADCAST);
   assign short_pkt = (packet_length < COUNT_BITS'(MIN_HDR_BYTES));

   always_comb begin
      if (short_pkt) begin
         status = STATUS_TOO_SHORT;
      end else if (header.ver_ihl_byte[7:4] != IP_VERSION_4) begin
         status = STATUS_BAD_VERSION;
      end else if ((hdr_bytes < 6'(MIN_HDR_BYTES))
                   || (COUNT_BITS'(hdr_bytes) > packet_length)) begin
         status = STATUS_BAD_HLEN;
      end else if ((header.destination == our_address_ff) || bcast
                   || (our_address_ff == ADDR_NONE)) begin
         status = STATUS_ACCEPT;
      end else begin
         status = STATUS_NOT_OURS;
      end
   end

   // Output valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload; a too-short packet reports zeros beside its status.
   always_ff @(posedge clock) begin
      if (out_load) begin
         status_ff <= status;
         if (short_pkt) begin
            class_ff       <= '0;
            protocol_ff    <= '0;
            ttl_ff         <= '0;
            source_ff      <= '0;
            destination_ff <= '0;
            hdr_bytes_ff   <= '0;
            payload_ff     <= '0;
            bcast_ff       <= 1'b0;
         end else begin
            class_ff       <= class_of(header.protocol);
            protocol_ff    <= header.protocol;
            ttl_ff         <= header.ttl;
            source_ff      <= header.source;
            destination_ff <= header.destination;
            hdr_bytes_ff   <= hdr_bytes;
            payload_ff     <= {1'b0, header.tot_len_word} - {11'b0, hdr_bytes};
            bcast_ff       <= bcast;
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = status_ff;
   assign rsp_proto_class         = class_ff;
   assign rsp_protocol_number     = protocol_ff;
   assign rsp_time_to_live        = ttl_ff;
   assign rsp_source_address      = source_ff;
   assign rsp_destination_address = destination_ff;
   assign rsp_header_bytes        = hdr_bytes_ff;
   assign rsp_payload_size        = signed'(payload_ff);
   assign rsp_broadcast           = bcast_ff;

   // A held verdict must freeze the input until it can move on.
   `IRHF_ASSERT_NOW(a_hold_blocks_input, pending && !out_load, !req_ready,
      "input accepted while a verdict is stuck")
   // A final byte always leaves a verdict behind.
   `IRHF_ASSERT_NEXT(a_last_sets_pending, take && req_last, pending,
      "final byte did not produce a pending verdict")
   // A loaded verdict is presented on the next cycle.
   `IRHF_ASSERT_NEXT(a_load_shows_valid, out_load, rsp_valid,
      "loaded verdict not presented")
   // An accepted packet has a header length of at least twenty bytes.
   `IRHF_ASSERT_NOW(a_accept_hlen, rsp_valid && (rsp_status == STATUS_ACCEPT),
      rsp_header_bytes >= 6'(MIN_HDR_BYTES), "accepted with a short header")
   // A too-short verdict carries zero fields.
   `IRHF_ASSERT_NOW(a_short_zero, rsp_valid && (rsp_status == STATUS_TOO_SHORT),
      (rsp_header_bytes == '0) && (rsp_source_address == '0) && !rsp_broadcast,
      "too-short verdict carries header fields")

endmodule

/* hw/rtl/irhf_capture.sv */
// Byte counter, header field capture and end-of-packet hold register.
module irhf_capture #(
   parameter int COUNT_BITS = irhf_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            data_byte,
   input  logic                  last,
   input  logic                  release_verdict,
   output logic                  pending,
   output logic [COUNT_BITS-1:0] packet_length,
   output irhf_pkg::hdr_type     header
);
   import irhf_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] POS_VER   = COUNT_BITS'(0);
   localparam logic [COUNT_BITS-1:0] POS_LEN_H = COUNT_BITS'(2);
   localparam logic [COUNT_BITS-1:0] POS_LEN_L = COUNT_BITS'(3);
   localparam logic [COUNT_BITS-1:0] POS_TTL   = COUNT_BITS'(8);
   localparam logic [COUNT_BITS-1:0] POS_PROTO = COUNT_BITS'(9);
   localparam logic [COUNT_BITS-1:0] POS_SRC_F = COUNT_BITS'(12);
   localparam logic [COUNT_BITS-1:0] POS_SRC_L = COUNT_BITS'(15);
   localparam logic [COUNT_BITS-1:0] POS_DST_F = COUNT_BITS'(16);
   localparam logic [COUNT_BITS-1:0] POS_DST_L = COUNT_BITS'(19);

   logic [COUNT_BITS-1:0] count_ff, count_in, count_inc;
   logic [COUNT_BITS-1:0] length_ff, length_in;
   logic                  pending_ff, pending_in;
   hdr_type               hdr_ff, hdr_in;

   // The count stops at its maximum; a saturated count stands as the length.
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

   // Next state of the counter, the held length and the pending flag.
   always_comb begin
      count_in   = count_ff;
      length_in  = length_ff;
      pending_in = pending_ff && !release_verdict;
      if (take) begin
         count_in = last ? '0 : count_inc;
         if (last) begin
            length_in  = count_inc;
            pending_in = 1'b1;
         end
      end
   end

   // Header bytes are picked out by position in the packet.
   always_comb begin
      hdr_in = hdr_ff;
      if (take) begin
         if (count_ff == POS_VER) begin
            hdr_in.ver_ihl_byte = data_byte;
         end else if (count_ff == POS_LEN_H) begin
            hdr_in.tot_len_word[15:8] = data_byte;
         end else if (count_ff == POS_LEN_L) begin
            hdr_in.tot_len_word[7:0] = data_byte;
         end else if (count_ff == POS_TTL) begin
            hdr_in.ttl = data_byte;
         end else if (count_ff == POS_PROTO) begin
            hdr_in.protocol = data_byte;
         end else if (count_ff inside {[POS_SRC_F:POS_SRC_L]}) begin
            hdr_in.source = {hdr_ff.source[23:0], data_byte};
         end else if (count_ff inside {[POS_DST_F:POS_DST_L]}) begin
            hdr_in.destination = {hdr_ff.destination[23:0], data_byte};
         end
      end
   end

   // State registers; every captured field starts at zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         length_ff  <= '0;
         pending_ff <= 1'b0;
         hdr_ff     <= '0;
      end else begin
         count_ff   <= count_in;
         length_ff  <= length_in;
         pending_ff <= pending_in;
         hdr_ff     <= hdr_in;
      end
   end

   assign pending       = pending_ff;
   assign packet_length = length_ff;
   assign header        = hdr_ff;

endmodule
